>>> rtl/mdx_pkg.sv
package mdx_pkg;

	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_J     = 6'h02;
	localparam logic [5:0] OP_BEQ   = 6'h04;
	localparam logic [5:0] OP_BNE   = 6'h05;
	localparam logic [5:0] OP_BGTZ  = 6'h07;
	localparam logic [5:0] OP_ADDI  = 6'h08;
	localparam logic [5:0] OP_ADDIU = 6'h09;
	localparam logic [5:0] OP_SLTI  = 6'h0a;
	localparam logic [5:0] OP_ORI   = 6'h0d;
	localparam logic [5:0] OP_LUI   = 6'h0f;
	localparam logic [5:0] OP_LW    = 6'h23;
	localparam logic [5:0] OP_SW    = 6'h2b;

	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_SLT  = 6'h2a;
	localparam logic [5:0] FN_SLTU = 6'h2b;

	typedef enum logic [3:0] {
		ALU_ZERO,
		ALU_ADD,
		ALU_SUB,
		ALU_SLT,
		ALU_SLTU,
		ALU_ADDI,
		ALU_LUI,
		ALU_SLTI,
		ALU_ORI,
		ALU_BEQ,
		ALU_BNE,
		ALU_BGTZ
	} alu_op_t;

	typedef struct packed {
		logic    reg_write;
		logic    mem_to_reg;
		logic    mem_read;
		logic    mem_write;
		logic    is_branch;
		logic    is_jump;
		logic    unknown_op;
		logic    dest_rd;
		alu_op_t alu_op;
	} ctrl_t;

endpackage

>>> rtl/mdx_decode.sv
module mdx_decode
	import mdx_pkg::*;
(
	input  logic [31:0] instruction,
	output ctrl_t       ctrl
);

	logic [5:0] op;
	logic [5:0] fn;

	assign op = instruction[31:26];
	assign fn = instruction[5:0];

	always_comb begin
		ctrl = '0;
		ctrl.alu_op = ALU_ZERO;
		if (instruction != '0) begin
			ctrl.dest_rd = (op == OP_RTYPE);
			case (op)
				OP_RTYPE: begin
					ctrl.reg_write = 1'b1;
					case (fn)
						FN_ADD, FN_ADDU: ctrl.alu_op = ALU_ADD;
						FN_SUB, FN_SUBU: ctrl.alu_op = ALU_SUB;
						FN_SLT:          ctrl.alu_op = ALU_SLT;
						FN_SLTU:         ctrl.alu_op = ALU_SLTU;
						default: begin
							ctrl.reg_write  = 1'b0;
							ctrl.unknown_op = 1'b1;
						end
					endcase
				end
				OP_LW: begin
					ctrl.reg_write  = 1'b1;
					ctrl.mem_to_reg = 1'b1;
					ctrl.mem_read   = 1'b1;
					ctrl.alu_op     = ALU_ADDI;
				end
				OP_SW: begin
					ctrl.mem_write = 1'b1;
					ctrl.alu_op    = ALU_ADDI;
				end
				OP_BEQ: begin
					ctrl.is_branch = 1'b1;
					ctrl.alu_op    = ALU_BEQ;
				end
				OP_BNE: begin
					ctrl.is_branch = 1'b1;
					ctrl.alu_op    = ALU_BNE;
				end
				OP_BGTZ: begin
					ctrl.is_branch = 1'b1;
					ctrl.alu_op    = ALU_BGTZ;
				end
				OP_J: begin
					ctrl.is_jump = 1'b1;
				end
				OP_LUI: begin
					ctrl.reg_write = 1'b1;
					ctrl.alu_op    = ALU_LUI;
				end
				OP_ADDI, OP_ADDIU: begin
					ctrl.reg_write = 1'b1;
					ctrl.alu_op    = ALU_ADDI;
				end
				OP_SLTI: begin
					ctrl.reg_write = 1'b1;
					ctrl.alu_op    = ALU_SLTI;
				end
				OP_ORI: begin
					ctrl.reg_write = 1'b1;
					ctrl.alu_op    = ALU_ORI;
				end
				default: begin
					ctrl.unknown_op = 1'b1;
				end
			endcase
		end
	end

endmodule

>>> rtl/mdx_alu.sv
module mdx_alu
	import mdx_pkg::*;
(
	input  alu_op_t     alu_op,
	input  logic [31:0] rs_data,
	input  logic [31:0] rt_data,
	input  logic [15:0] imm,
	output logic [31:0] result,
	output logic        taken
);

	logic [31:0] simm;
	logic [31:0] diff;
	logic        gtz;

	assign simm = {{16{imm[15]}}, imm};
	assign diff = rs_data - rt_data;
	assign gtz  = !rs_data[31] && (rs_data != '0);

	always_comb begin
		result = '0;
		taken  = 1'b0;
		case (alu_op)
			ALU_ADD:  result = rs_data + rt_data;
			ALU_SUB:  result = diff;
			ALU_SLT:  result = {31'd0, $signed(rs_data) < $signed(rt_data)};
			ALU_SLTU: result = {31'd0, rs_data < rt_data};
			ALU_ADDI: result = rs_data + simm;
			ALU_LUI:  result = {imm, 16'd0};
			ALU_SLTI: result = {31'd0, $signed(rs_data) < $signed(simm)};
			ALU_ORI:  result = rs_data | {16'd0, imm};
			ALU_BEQ: begin
				result = diff;
				taken  = (diff == '0);
			end
			ALU_BNE: begin
				result = diff;
				taken  = (diff != '0);
			end
			ALU_BGTZ: begin
				result = {31'd0, gtz};
				taken  = gtz;
			end
			default: begin
				result = '0;
				taken  = 1'b0;
			end
		endcase
	end

endmodule

>>> rtl/mips_decode_execute_stage.sv
// A word accepted by start goes through the input register, then decode and one 32-bit
// ALU operation into the result register, and shows on the result ports with done high.
// Throughput: one word per cycle; busy is always low.
// The receiver cannot stall; done is high for a single cycle per word, and the results are held until the next word.
// Reset: arst_n clears the valid flags; no result is shown until a new start.
module mips_decode_execute_stage
	import mdx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] instruction,
	input  logic [31:0] rs_data,
	input  logic [31:0] rt_data,
	input  logic [31:0] next_pc,
	output logic        done,
	output logic [31:0] alu_result,
	output logic        taken,
	output logic [31:0] branch_target,
	output logic [31:0] jump_target,
	output logic [4:0]  dest_reg,
	output logic        reg_write,
	output logic        mem_to_reg,
	output logic        mem_read,
	output logic        mem_write,
	output logic        is_branch,
	output logic        is_jump,
	output logic        unknown_op
);

	logic        valid_s1;
	logic [31:0] instr_s1;
	logic [31:0] rs_s1;
	logic [31:0] rt_s1;
	logic [31:0] npc_s1;

	ctrl_t       ctrl;
	logic [31:0] alu_res;
	logic        alu_taken;
	logic        bubble;
	logic [31:0] btgt;
	logic [31:0] jtgt;
	logic [4:0]  dst;

	logic        valid_s2;
	logic [31:0] res_s2;
	logic        taken_s2;
	logic [31:0] btgt_s2;
	logic [31:0] jtgt_s2;
	logic [4:0]  dst_s2;
	ctrl_t       ctrl_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			instr_s1 <= instruction;
			rs_s1    <= rs_data;
			rt_s1    <= rt_data;
			npc_s1   <= next_pc;
		end
	end

	mdx_decode u_decode (
		.instruction (instr_s1),
		.ctrl        (ctrl)
	);

	mdx_alu u_alu (
		.alu_op  (ctrl.alu_op),
		.rs_data (rs_s1),
		.rt_data (rt_s1),
		.imm     (instr_s1[15:0]),
		.result  (alu_res),
		.taken   (alu_taken)
	);

	assign bubble = (instr_s1 == '0);
	assign btgt   = bubble ? '0 : npc_s1 + {{14{instr_s1[15]}}, instr_s1[15:0], 2'b00};
	assign jtgt   = bubble ? '0 : {npc_s1[31:28], instr_s1[25:0], 2'b00};
	assign dst    = bubble ? '0 : (ctrl.dest_rd ? instr_s1[15:11] : instr_s1[20:16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2   <= alu_res;
			taken_s2 <= alu_taken;
			btgt_s2  <= btgt;
			jtgt_s2  <= jtgt;
			dst_s2   <= dst;
			ctrl_s2  <= ctrl;
		end
	end

	assign done          = valid_s2;
	assign alu_result    = res_s2;
	assign taken         = taken_s2;
	assign branch_target = btgt_s2;
	assign jump_target   = jtgt_s2;
	assign dest_reg      = dst_s2;
	assign reg_write     = ctrl_s2.reg_write;
	assign mem_to_reg    = ctrl_s2.mem_to_reg;
	assign mem_read      = ctrl_s2.mem_read;
	assign mem_write     = ctrl_s2.mem_write;
	assign is_branch     = ctrl_s2.is_branch;
	assign is_jump       = ctrl_s2.is_jump;
	assign unknown_op    = ctrl_s2.unknown_op;

endmodule

>>> rtl/mdx_checker.sv
module mdx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] alu_result,
	input logic        taken,
	input logic        reg_write,
	input logic        mem_read,
	input logic        mem_to_reg,
	input logic        is_branch,
	input logic        unknown_op
);

	a_word_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted word produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> ##1 !done)
		else $error("result without accepted word");

	a_unknown_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && unknown_op) |-> (alu_result == '0 && !taken && !reg_write && !is_branch))
		else $error("unknown op not cleared");

	a_taken_branch: assert property (@(posedge clk) disable iff (!arst_n)
		(done && taken) |-> is_branch)
		else $error("taken without branch");

	a_load_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		(done && mem_to_reg) |-> (mem_read && reg_write))
		else $error("load controls inconsistent");

endmodule

bind mips_decode_execute_stage mdx_checker u_mdx_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.alu_result (alu_result),
	.taken      (taken),
	.reg_write  (reg_write),
	.mem_read   (mem_read),
	.mem_to_reg (mem_to_reg),
	.is_branch  (is_branch),
	.unknown_op (unknown_op)
);
